[src/cpvpi_pkg.sv]
// ----------------------------------------------------------------------------
// cpvpi_pkg
// Shared types and constants for the cascaded position/velocity PI unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cpvpi_pkg;

  // Outer position loop runs once every OUTER_PERIOD ticks
  localparam logic [2:0] OUTER_PERIOD = 3'd5;

  // Shared divider geometry
  localparam int unsigned DIV_W  = 52;
  localparam int unsigned DIVR_W = 31;
  localparam int unsigned DCNT_W = 6;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_SINGLE_CHANNEL = 3'd0,
    CFG_TICKS_PER_UNIT = 3'd1,
    CFG_TICK_RATE      = 3'd2,
    CFG_POS_GAIN       = 3'd3,
    CFG_SPEED_KP       = 3'd4,
    CFG_SPEED_KI       = 3'd5,
    CFG_SPEED_LIMIT    = 3'd6
  } cfg_idx_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPD_MUL,
    ST_SPD_LOAD,
    ST_SPD_DIV,
    ST_SPD_DONE,
    ST_OUT_MUL,
    ST_OUT_DONE,
    ST_ERR,
    ST_AW_DIV,
    ST_INT,
    ST_MQ_LO_W,
    ST_MQ_HI,
    ST_MQ_HI_W,
    ST_MQ_SUM,
    ST_FINISH
  } state_e;

endpackage

`default_nettype wire

[src/cpvpi_div.sv]
// ----------------------------------------------------------------------------
// cpvpi_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cpvpi_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [cpvpi_pkg::DIV_W-1:0]   dividend_i,
  input  wire logic [cpvpi_pkg::DIVR_W-1:0]  divisor_i,
  output logic                               done_o,
  output logic [cpvpi_pkg::DIV_W-1:0]        quot_o
);
  import cpvpi_pkg::*;

  localparam logic [DCNT_W-1:0] LastStep = DCNT_W'(DIV_W - 1);

  logic                busy_q;
  logic                done_q;
  logic [DCNT_W-1:0]   cnt_q;
  logic [DIV_W-1:0]    dq_q;
  logic [DIVR_W-1:0]   rem_q;
  logic [DIVR_W-1:0]   dvs_q;
  logic [DIVR_W:0]     rem_sh;
  logic                ge;
  logic [DIVR_W:0]     rem_sub;

  // Trial subtract of the shifted partial remainder
  always_comb begin
    rem_sh  = {rem_q, dq_q[DIV_W-1]};
    ge      = rem_sh >= {1'b0, dvs_q};
    rem_sub = rem_sh - {1'b0, dvs_q};
  end

  // Control: run DIV_W steps after start, pulse done when the quotient is ready
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == LastStep);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == LastStep) begin
          busy_q <= 1'b0;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Datapath: shift dividend out, quotient bits in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      dq_q  <= {dq_q[DIV_W-2:0], ge};
      rem_q <= ge ? rem_sub[DIVR_W-1:0] : rem_sh[DIVR_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = dq_q;

endmodule

`default_nettype wire

[src/cascaded_position_velocity_pi_unit.sv]
// ----------------------------------------------------------------------------
// cascaded_position_velocity_pi_unit
// Cascaded position/velocity PI motor controller, one result per tick.
// ----------------------------------------------------------------------------
// Each accepted tick updates position and measured speed from the encoder
// count, runs the outer proportional position loop every fifth tick, then the
// inner PI speed loop with back-calculation anti-windup, and returns a duty
// magnitude, a direction, the speed and the position. Work runs on one shared
// 33x31 multiplier and one bit-serial divider under a sequencer. A tick's
// time is dominated by two 52-step divisions (speed scaling and the
// anti-windup term, the latter skipped with speed_ki zero); outer-loop ticks
// add the ST_OUT_MUL and ST_OUT_DONE states, and the final step waits while
// the output is stalled. The next tick is taken once the result is in the
// output register; the output register holds it until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module cascaded_position_velocity_pi_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_addr_i,
  input  wire logic [30:0] cfg_wdata_i,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] enc_count_i,
  input  wire logic [31:0] pos_target_i,
  // output channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       pwm_duty_o,
  output logic             forward_o,
  output logic [31:0]      speed_meas_o,
  output logic [31:0]      position_meas_o
);
  import cpvpi_pkg::*;

  localparam logic signed [52:0] AccMax = 53'sd140737488355327;
  localparam logic signed [52:0] AccMin = -53'sd140737488355327;

  // Configuration registers
  logic        single_q;
  logic [19:0] tpu_q;
  logic [19:0] rate_q;
  logic [30:0] pgain_q;
  logic [30:0] kp_q;
  logic [30:0] ki_q;
  logic [30:0] lim_q;

  // Controller state
  logic [31:0]        prev_q;
  logic [31:0]        pos_q;
  logic               fwd_q;
  logic [2:0]         otick_q;
  logic signed [31:0] tgt_q;
  logic signed [47:0] integ_q;
  logic signed [31:0] lout_q;
  logic signed [31:0] applied_q;

  // Work registers
  state_e             state_q, state_d;
  logic               do_outer_q;
  logic               spd_neg_q;
  logic               tneg_q;
  logic               aw_neg_q;
  logic [31:0]        ptgt_q;
  logic signed [31:0] speed_q;
  logic signed [49:0] err_q;
  logic               mq_neg_q;
  logic               mq_sel_q;
  logic [47:0]        mq_mag_q;
  logic [63:0]        acc_q;
  logic signed [49:0] cmd_q;
  logic [32:0]        mul_a_q;
  logic [30:0]        mul_b_q;
  logic [63:0]        prod_q;

  // Output register
  logic        out_valid_q;
  logic [7:0]  out_duty_q;
  logic        out_fwd_q;
  logic [31:0] out_speed_q;
  logic [31:0] out_pos_q;

  // Divider handshake
  logic                 div_start;
  logic [DIV_W-1:0]     div_dividend;
  logic [DIVR_W-1:0]    div_divisor;
  logic                 div_done;
  logic [DIV_W-1:0]     div_quot;

  logic accept;
  logic ki_nz;
  logic fin_go;

  assign ki_nz  = ki_q != '0;
  assign accept = in_valid_i && in_ready_o;
  assign fin_go = !out_valid_q || out_ready_i;

  cpvpi_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // ---------------------------------------------------------------------------
  // Combinational datapath terms
  // ---------------------------------------------------------------------------
  logic [31:0]        delta_raw, delta, pos_next;
  logic [32:0]        delta_mag;
  logic signed [31:0] spd_val;
  logic [32:0]        pdiff, pdiff_mag;
  logic [30:0]        tgt_mag;
  logic signed [49:0] err_val;
  logic [32:0]        adiff, adiff_mag;
  logic signed [50:0] aw_val;
  logic signed [52:0] int_sum;
  logic signed [47:0] int_val;
  logic [49:0]        err_mag;
  logic [47:0]        int_mag;
  logic [95:0]        mq_full;
  logic [79:0]        mq_shr;
  logic [47:0]        mq_sat;
  logic signed [49:0] mq_term;
  logic signed [31:0] lout_val;
  logic [32:0]        lout_mag;
  logic [24:0]        duty_raw;
  logic [7:0]         duty_mag;
  logic [31:0]        applied_mag;

  always_comb begin
    // Position and count delta
    delta_raw = enc_count_i - prev_q;
    delta     = (single_q && fwd_q) ? (32'd0 - delta_raw) : delta_raw;
    pos_next  = single_q ? (pos_q + delta) : enc_count_i;
    delta_mag = delta[31] ? (33'd0 - {1'b1, delta}) : {1'b0, delta};

    // Signed speed from the quotient, saturated to 32 bits
    if (spd_neg_q) begin
      spd_val = (div_quot > 52'h0_0000_8000_0000) ? 32'sh8000_0000
                                                   : -$signed(div_quot[31:0]);
    end else begin
      spd_val = (div_quot > 52'h0_0000_7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                   : $signed(div_quot[31:0]);
    end

    // Outer position error and clamp of its product
    pdiff     = {ptgt_q[31], ptgt_q} - {pos_q[31], pos_q};
    pdiff_mag = pdiff[32] ? (33'd0 - pdiff) : pdiff;
    tgt_mag   = (prod_q > {33'd0, lim_q}) ? lim_q : prod_q[30:0];

    // Speed error in Q16.16
    err_val = 50'(tgt_q) - 50'($signed({speed_q, 16'h0000}));

    // Anti-windup difference and integrator update
    adiff     = {lout_q[31], lout_q} - {applied_q[31], applied_q};
    adiff_mag = adiff[32] ? (33'd0 - adiff) : adiff;
    aw_val    = aw_neg_q ? -$signed({1'b0, div_quot[49:0]}) : $signed({1'b0, div_quot[49:0]});
    if (!ki_nz) begin
      aw_val = '0;
    end
    int_sum = 53'(integ_q) + 53'(err_q) - 53'(aw_val);
    priority if (int_sum > AccMax) begin
      int_val = AccMax[47:0];
    end else if (int_sum < AccMin) begin
      int_val = AccMin[47:0];
    end else begin
      int_val = int_sum[47:0];
    end

    // Magnitudes fed to the gain products
    err_mag = err_q[49] ? 50'(-err_q) : 50'(err_q);
    int_mag = integ_q[47] ? 48'(-integ_q) : 48'(integ_q);

    // Gain product: drop 16 fraction bits, saturate at 2^47
    mq_full = {32'd0, acc_q} + {prod_q, 32'd0};
    mq_shr  = mq_full[95:16];
    mq_sat  = (mq_shr > 80'h8000_0000_0000) ? 48'h8000_0000_0000 : mq_shr[47:0];
    mq_term = mq_neg_q ? -$signed({2'b00, mq_sat}) : $signed({2'b00, mq_sat});

    // Command saturation and duty quantization
    priority if (cmd_q > 50'sh0_0000_7FFF_FFFF) begin
      lout_val = 32'sh7FFF_FFFF;
    end else if (cmd_q < -50'sh0_0000_8000_0000) begin
      lout_val = 32'sh8000_0000;
    end else begin
      lout_val = cmd_q[31:0];
    end
    lout_mag    = lout_val[31] ? (33'd0 - {1'b1, lout_val}) : {1'b0, lout_val};
    duty_raw    = lout_mag[32:8];
    duty_mag    = (duty_raw > 25'd255) ? 8'd255 : duty_raw[7:0];
    applied_mag = {16'd0, duty_mag, 8'd0};
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (accept) state_d = ST_SPD_MUL;
      ST_SPD_MUL:  state_d = ST_SPD_LOAD;
      ST_SPD_LOAD: state_d = ST_SPD_DIV;
      ST_SPD_DIV:  if (div_done) state_d = ST_SPD_DONE;
      ST_SPD_DONE: state_d = do_outer_q ? ST_OUT_MUL : ST_ERR;
      ST_OUT_MUL:  state_d = ST_OUT_DONE;
      ST_OUT_DONE: state_d = ST_ERR;
      ST_ERR:      state_d = ki_nz ? ST_AW_DIV : ST_INT;
      ST_AW_DIV:   if (div_done) state_d = ST_INT;
      ST_INT:      state_d = ST_MQ_LO_W;
      ST_MQ_LO_W:  state_d = ST_MQ_HI;
      ST_MQ_HI:    state_d = ST_MQ_HI_W;
      ST_MQ_HI_W:  state_d = ST_MQ_SUM;
      ST_MQ_SUM:   state_d = (!mq_sel_q && ki_nz) ? ST_MQ_LO_W : ST_FINISH;
      ST_FINISH:   if (fin_go) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: control outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ready_o   = 1'b0;
    div_start    = 1'b0;
    div_dividend = {1'b0, prod_q[50:0]};
    div_divisor  = (tpu_q == '0) ? 31'd1 : {11'd0, tpu_q};
    unique case (state_q)
      ST_IDLE:     in_ready_o = 1'b1;
      ST_SPD_LOAD: div_start  = 1'b1;
      ST_ERR: begin
        div_start    = ki_nz;
        div_dividend = {3'd0, adiff_mag, 16'h0000};
        div_divisor  = ki_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      single_q <= 1'b0;
      tpu_q    <= 20'd1;
      rate_q   <= 20'd1000;
      pgain_q  <= '0;
      kp_q     <= '0;
      ki_q     <= '0;
      lim_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_SINGLE_CHANNEL: single_q <= cfg_wdata_i[0];
        CFG_TICKS_PER_UNIT: tpu_q    <= cfg_wdata_i[19:0];
        CFG_TICK_RATE:      rate_q   <= cfg_wdata_i[19:0];
        CFG_POS_GAIN:       pgain_q  <= cfg_wdata_i;
        CFG_SPEED_KP:       kp_q     <= cfg_wdata_i;
        CFG_SPEED_KI:       ki_q     <= cfg_wdata_i;
        CFG_SPEED_LIMIT:    lim_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Shared multiplier, registered
  always_ff @(posedge clk_i) begin
    prod_q <= {31'd0, mul_a_q} * {33'd0, mul_b_q};
  end

  // Controller state that persists across ticks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= '0;
      pos_q      <= '0;
      fwd_q      <= 1'b1;
      otick_q    <= '0;
      tgt_q      <= '0;
      integ_q    <= '0;
      lout_q     <= '0;
      applied_q  <= '0;
      do_outer_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: if (accept) begin
          prev_q     <= enc_count_i;
          pos_q      <= pos_next;
          do_outer_q <= otick_q >= OUTER_PERIOD;
          otick_q    <= (otick_q >= OUTER_PERIOD) ? 3'd1 : (otick_q + 3'd1);
        end
        ST_OUT_DONE: tgt_q <= tneg_q ? -$signed({1'b0, tgt_mag}) : $signed({1'b0, tgt_mag});
        ST_INT:      integ_q <= int_val;
        ST_FINISH: if (fin_go) begin
          lout_q    <= lout_val;
          fwd_q     <= !lout_val[31] && (lout_val != '0);
          applied_q <= lout_val[31] ? -$signed(applied_mag) : $signed(applied_mag);
        end
        default: ;
      endcase
    end
  end

  // Work registers of the current tick
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: if (accept) begin
        ptgt_q    <= pos_target_i;
        spd_neg_q <= delta[31];
        mul_a_q   <= delta_mag;
        mul_b_q   <= {11'd0, rate_q};
      end
      ST_SPD_DONE: begin
        speed_q <= spd_val;
        tneg_q  <= pdiff[32];
        mul_a_q <= pdiff_mag;
        mul_b_q <= pgain_q;
      end
      ST_ERR: begin
        err_q    <= err_val;
        aw_neg_q <= adiff[32];
      end
      ST_INT: begin
        cmd_q    <= '0;
        mq_sel_q <= 1'b0;
        mq_neg_q <= err_q[49];
        mq_mag_q <= err_mag[47:0];
        mul_a_q  <= {1'b0, err_mag[31:0]};
        mul_b_q  <= kp_q;
      end
      ST_MQ_HI: begin
        acc_q   <= prod_q;
        mul_a_q <= {17'd0, mq_mag_q[47:32]};
        mul_b_q <= mq_sel_q ? ki_q : kp_q;
      end
      ST_MQ_SUM: begin
        cmd_q    <= cmd_q + mq_term;
        mq_sel_q <= 1'b1;
        mq_neg_q <= integ_q[47];
        mq_mag_q <= int_mag;
        mul_a_q  <= {1'b0, int_mag[31:0]};
        mul_b_q  <= ki_q;
      end
      default: ;
    endcase
  end

  // Output register: hold a result until its transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_FINISH && fin_go) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FINISH && fin_go) begin
      out_duty_q  <= duty_mag;
      out_fwd_q   <= !lout_val[31] && (lout_val != '0);
      out_speed_q <= speed_q;
      out_pos_q   <= pos_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pwm_duty_o      = out_duty_q;
  assign forward_o       = out_fwd_q;
  assign speed_meas_o    = out_speed_q;
  assign position_meas_o = out_pos_q;

endmodule

`default_nettype wire
